@@ rtl/core/slbm_pkg.sv @@
// Shared types and constants for the serial loaded bank mapper.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package slbm_pkg;

  localparam int AddrW     = 16;
  localparam int DataW     = 8;
  localparam int PrgBankW  = 4;
  localparam int ChrBankW  = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 3;
  localparam int ShiftW    = 5;
  localparam int CountW    = 3;

  localparam logic [CountW-1:0] LastShift      = CountW'(ShiftW - 1);
  localparam logic [2:0]        PrgBitsMax     = 3'd4;
  localparam logic [2:0]        ChrBitsMax     = 3'd5;
  localparam logic [2:0]        PrgBitsReset   = 3'd3;
  localparam logic [2:0]        ChrBitsReset   = 3'd5;
  localparam logic [1:0]        MirrorReset    = 2'd2;
  localparam logic [1:0]        PrgModeFixLast = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRG_BANK_BITS  = 2'd0,
    CFG_CHR_BANK_BITS  = 2'd1,
    CFG_CHR_IS_RAM     = 2'd2,
    CFG_POWER_ON_MIRROR = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG      = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A = 2'd0,
    PRG_MODE_32K_B = 2'd1,
    PRG_MODE_FIX_FIRST = 2'd2,
    PRG_MODE_FIX_LAST  = 2'd3
  } prg_mode_t;

endpackage

@@ rtl/core/slbm_req_if.sv @@
// Request channel: one processor write to the cartridge area.
// Depends on slbm_pkg for field widths.
`timescale 1ns / 1ps

interface slbm_req_if
  import slbm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] write_address;
  logic [DataW-1:0] write_data;

  modport source (output valid, output write_address, output write_data, input ready);
  modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

@@ rtl/core/slbm_rsp_if.sv @@
// Result channel: bank numbers and mirroring after each request.
// Depends on slbm_pkg for field widths.
`timescale 1ns / 1ps

interface slbm_rsp_if
  import slbm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [1:0]          mirroring;
  logic [PrgBankW-1:0] prg_bank_first;
  logic [PrgBankW-1:0] prg_bank_second;
  logic [ChrBankW-1:0] chr_bank_first;
  logic [ChrBankW-1:0] chr_bank_second;
  logic                prg_ram_writable;
  logic                register_loaded;

  modport source (output valid, output mirroring, output prg_bank_first,
                  output prg_bank_second, output chr_bank_first, output chr_bank_second,
                  output prg_ram_writable, output register_loaded, input ready);
  modport sink   (input valid, input mirroring, input prg_bank_first,
                  input prg_bank_second, input chr_bank_first, input chr_bank_second,
                  input prg_ram_writable, input register_loaded, output ready);
endinterface

@@ rtl/core/slbm_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on slbm_pkg for field widths.
`timescale 1ns / 1ps

interface slbm_cfg_if
  import slbm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/serial_loaded_bank_mapper_top.sv @@
// Serial loaded bank mapper: five-bit serial shifter, bank registers and bank decode.
// Depends on slbm_pkg and the slbm_req_if, slbm_rsp_if, slbm_cfg_if interfaces.
//
//   channel  dir  payload
//   req      in   write_address[15:0], write_data[7:0]
//   rsp      out  mirroring, prg/chr bank numbers, prg_ram_writable, register_loaded
//   cfg      in   index[1:0], data[2:0]
//
// One request per cycle while not stalled; the result is registered for the next cycle.
// Mapper state updates on the request edge and the bank decode feeds the result register.
// req.ready is low only while a result is held and rsp.ready is low.
// cfg.ready is always high. rst is synchronous and restores power-on state.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_top
  import slbm_pkg::*;
  (
  input  logic      clk,
  input  logic      rst,
  slbm_req_if.sink  req,
  slbm_rsp_if.source rsp,
  slbm_cfg_if.sink  cfg
);

  logic [2:0]          prg_bank_bits;
  logic [2:0]          chr_bank_bits;
  logic                chr_is_ram;

  logic [ShiftW-1:0]   shift_value, shift_value_next;
  logic [CountW-1:0]   shift_count, shift_count_next;
  logic [1:0]          prg_mode, prg_mode_next;
  logic                chr_mode, chr_mode_next;
  logic [PrgBankW-1:0] prg_select, prg_select_next;
  logic [ChrBankW-1:0] chr_select_low, chr_select_low_next;
  logic [ChrBankW-1:0] chr_select_high, chr_select_high_next;
  logic [1:0]          mirror_mode, mirror_mode_next;
  logic                ram_write_enable, ram_write_enable_next;
  logic                loaded;

  logic                req_fire;
  logic                mirror_cfg_wr;
  logic [ShiftW-1:0]   shifted;
  logic [2:0]          prg_bits_eff;
  logic [2:0]          chr_bits_eff;
  logic [PrgBankW-1:0] pmask;
  logic [ChrBankW-1:0] cmask;
  logic [PrgBankW-1:0] pf, ps;
  logic [ChrBankW-1:0] cf, cs;

  assign req.ready = !rsp.valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign mirror_cfg_wr = cfg.valid && (cfg_index_t'(cfg.index) == CFG_POWER_ON_MIRROR);

  // serial load and register update
  always_comb begin
    shift_value_next      = shift_value;
    shift_count_next      = shift_count;
    prg_mode_next         = prg_mode;
    chr_mode_next         = chr_mode;
    prg_select_next       = prg_select;
    chr_select_low_next   = chr_select_low;
    chr_select_high_next  = chr_select_high;
    mirror_mode_next      = mirror_mode;
    ram_write_enable_next = ram_write_enable;
    loaded                = 1'b0;
    shifted = {req.write_data[0], shift_value[ShiftW-1:1]};
    if (req.write_data[DataW-1]) begin
      shift_value_next = '0;
      shift_count_next = '0;
      prg_mode_next    = PrgModeFixLast;
    end else if (shift_count == LastShift) begin
      shift_value_next = '0;
      shift_count_next = '0;
      loaded           = 1'b1;
      case (target_t'(req.write_address[14:13]))
        TGT_CONTROL: begin
          mirror_mode_next = shifted[1:0];
          prg_mode_next    = shifted[3:2];
          chr_mode_next    = shifted[4];
        end
        TGT_CHR_LOW: begin
          chr_select_low_next = shifted;
        end
        TGT_CHR_HIGH: begin
          chr_select_high_next = shifted;
        end
        TGT_PRG: begin
          ram_write_enable_next = !shifted[4];
          prg_select_next       = shifted[3:0];
        end
        default: begin
          prg_select_next = prg_select;
        end
      endcase
    end else begin
      shift_value_next = shifted;
      shift_count_next = shift_count + CountW'(1);
    end
  end

  // bank decode from the updated state
  always_comb begin
    prg_bits_eff = (prg_bank_bits > PrgBitsMax) ? PrgBitsMax : prg_bank_bits;
    chr_bits_eff = (chr_bank_bits > ChrBitsMax) ? ChrBitsMax : chr_bank_bits;
    pmask = PrgBankW'(((PrgBankW+1)'(1) << prg_bits_eff) - (PrgBankW+1)'(1));
    cmask = ChrBankW'(((ChrBankW+1)'(1) << chr_bits_eff) - (ChrBankW+1)'(1));
    case (prg_mode_t'(prg_mode_next))
      PRG_MODE_32K_A, PRG_MODE_32K_B: begin
        pf = {prg_select_next[PrgBankW-1:1], 1'b0} & pmask;
        ps = (pf + PrgBankW'(1)) & pmask;
      end
      PRG_MODE_FIX_FIRST: begin
        pf = '0;
        ps = prg_select_next & pmask;
      end
      default: begin
        pf = prg_select_next & pmask;
        ps = pmask;
      end
    endcase
    if (chr_is_ram) begin
      cf = '0;
      cs = '0;
    end else if (!chr_mode_next) begin
      cf = {chr_select_low_next[ChrBankW-1:1], 1'b0} & cmask;
      cs = (cf + ChrBankW'(1)) & cmask;
    end else begin
      cf = chr_select_low_next & cmask;
      cs = chr_select_high_next & cmask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_bits      <= PrgBitsReset;
      chr_bank_bits      <= ChrBitsReset;
      chr_is_ram         <= 1'b0;
      shift_value        <= '0;
      shift_count        <= '0;
      prg_mode           <= PrgModeFixLast;
      chr_mode           <= 1'b0;
      prg_select         <= '0;
      chr_select_low     <= '0;
      chr_select_high    <= '0;
      mirror_mode        <= MirrorReset;
      ram_write_enable   <= 1'b1;
    end else begin
      if (req_fire) begin
        shift_value      <= shift_value_next;
        shift_count      <= shift_count_next;
        prg_mode         <= prg_mode_next;
        chr_mode         <= chr_mode_next;
        prg_select       <= prg_select_next;
        chr_select_low   <= chr_select_low_next;
        chr_select_high  <= chr_select_high_next;
        ram_write_enable <= ram_write_enable_next;
        if (!mirror_cfg_wr) begin
          mirror_mode    <= mirror_mode_next;
        end
      end
      if (cfg.valid) begin
        case (cfg_index_t'(cfg.index))
          CFG_PRG_BANK_BITS:  prg_bank_bits <= cfg.data;
          CFG_CHR_BANK_BITS:  chr_bank_bits <= cfg.data;
          CFG_CHR_IS_RAM:     chr_is_ram    <= cfg.data[0];
          CFG_POWER_ON_MIRROR: begin
            mirror_mode        <= cfg.data[1:0];
          end
          default: chr_is_ram <= chr_is_ram;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req.ready) begin
      rsp.valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.mirroring        <= mirror_mode_next;
      rsp.prg_bank_first   <= pf;
      rsp.prg_bank_second  <= ps;
      rsp.chr_bank_first   <= cf;
      rsp.chr_bank_second  <= cs;
      rsp.prg_ram_writable <= ram_write_enable_next;
      rsp.register_loaded  <= loaded;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    shift_count <= LastShift)
    else $error("shift count past last bit");

  a_req_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> rsp.valid)
    else $error("accepted request produced no result");

  a_reset_write_no_load: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.write_data[DataW-1] |=> !rsp.register_loaded && (shift_count == '0))
    else $error("shifter reset write reported a load");

  a_chr_ram_zero: assert property (@(posedge clk) disable iff (rst)
    req_fire && chr_is_ram |=> (rsp.chr_bank_first == '0) && (rsp.chr_bank_second == '0))
    else $error("pattern banks nonzero with pattern RAM");

endmodule

@@ tb/sv/serial_loaded_bank_mapper_top_tb.sv @@
// Testbench for serial_loaded_bank_mapper_top: directed and random processor writes
// checked against an in-bench mapper predictor. Depends on slbm_pkg and the req/rsp/cfg interfaces.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_top_tb;
  import slbm_pkg::*;

  typedef struct packed {
    logic [1:0]          mirroring;
    logic [PrgBankW-1:0] prg_first;
    logic [PrgBankW-1:0] prg_second;
    logic [ChrBankW-1:0] chr_first;
    logic [ChrBankW-1:0] chr_second;
    logic                ram_writable;
    logic                loaded;
  } bank_view_t;

  logic clk = 1'b0;
  logic rst;

  slbm_req_if req_if ();
  slbm_rsp_if rsp_if ();
  slbm_cfg_if cfg_if ();

  serial_loaded_bank_mapper_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted mapper state
  logic [ShiftW-1:0]   shift_bits;
  logic [CountW-1:0]   shift_cnt;
  prg_mode_t           prg_mode;
  logic                chr_mode;
  logic [PrgBankW-1:0] prg_sel;
  logic [ChrBankW-1:0] chr_sel_low;
  logic [ChrBankW-1:0] chr_sel_high;
  logic [1:0]          mirror_mode;
  logic                ram_we;
  logic [2:0]          prg_bits;
  logic [2:0]          chr_bits;
  logic                chr_ram;
  logic [1:0]          boot_mirror;

  bank_view_t expected_views[$];

  int errors = 0;
  int writes_sent = 0;
  int views_checked = 0;
  int loads_seen = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void reset_mapper();
    prg_bits     = PrgBitsReset;
    chr_bits     = ChrBitsReset;
    chr_ram      = 1'b0;
    boot_mirror  = MirrorReset;
    shift_bits   = '0;
    shift_cnt    = '0;
    prg_mode     = PRG_MODE_FIX_LAST;
    chr_mode     = 1'b0;
    prg_sel      = '0;
    chr_sel_low  = '0;
    chr_sel_high = '0;
    mirror_mode  = MirrorReset;
    ram_we       = 1'b1;
  endfunction

  function automatic void apply_config(cfg_index_t idx, logic [CfgDataW-1:0] d);
    case (idx)
      CFG_PRG_BANK_BITS: prg_bits = d;
      CFG_CHR_BANK_BITS: chr_bits = d;
      CFG_CHR_IS_RAM:    chr_ram  = d[0];
      CFG_POWER_ON_MIRROR: begin
        boot_mirror = d[1:0];
        mirror_mode = d[1:0];
      end
      default: ;
    endcase
  endfunction

  function automatic bank_view_t apply_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    bank_view_t v;
    int pb;
    int cb;
    logic [PrgBankW-1:0] pmask;
    logic [ChrBankW-1:0] cmask;
    v = '0;
    if (!data[7]) begin
      shift_bits = {data[0], shift_bits[ShiftW-1:1]};
      shift_cnt  = shift_cnt + 1'b1;
      if (shift_cnt >= ShiftW) begin
        case (target_t'(addr[14:13]))
          TGT_CONTROL: begin
            mirror_mode = shift_bits[1:0];
            prg_mode    = prg_mode_t'(shift_bits[3:2]);
            chr_mode    = shift_bits[4];
          end
          TGT_CHR_LOW:  chr_sel_low  = shift_bits;
          TGT_CHR_HIGH: chr_sel_high = shift_bits;
          default: begin
            ram_we  = ~shift_bits[4];
            prg_sel = shift_bits[3:0];
          end
        endcase
        shift_bits = '0;
        shift_cnt  = '0;
        v.loaded   = 1'b1;
      end
    end else begin
      shift_bits = '0;
      shift_cnt  = '0;
      prg_mode   = PRG_MODE_FIX_LAST;
    end

    pb = int'((prg_bits > PrgBitsMax) ? PrgBitsMax : prg_bits);
    cb = int'((chr_bits > ChrBitsMax) ? ChrBitsMax : chr_bits);
    pmask = PrgBankW'((1 << pb) - 1);
    cmask = ChrBankW'((1 << cb) - 1);

    case (prg_mode)
      PRG_MODE_32K_A, PRG_MODE_32K_B: begin
        v.prg_first  = {prg_sel[PrgBankW-1:1], 1'b0} & pmask;
        v.prg_second = (v.prg_first + 1'b1) & pmask;
      end
      PRG_MODE_FIX_FIRST: begin
        v.prg_first  = '0;
        v.prg_second = prg_sel & pmask;
      end
      default: begin
        v.prg_first  = prg_sel & pmask;
        v.prg_second = pmask;
      end
    endcase

    if (chr_ram) begin
      v.chr_first  = '0;
      v.chr_second = '0;
    end else if (!chr_mode) begin
      v.chr_first  = {chr_sel_low[ChrBankW-1:1], 1'b0} & cmask;
      v.chr_second = (v.chr_first + 1'b1) & cmask;
    end else begin
      v.chr_first  = chr_sel_low & cmask;
      v.chr_second = chr_sel_high & cmask;
    end

    v.mirroring    = mirror_mode;
    v.ram_writable = ram_we;
    return v;
  endfunction

  function automatic void check_field(string name, logic [4:0] exp_v, logic [4:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    bank_view_t want;
    if (rst) begin
      reset_mapper();
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual mirroring %0d",
                   $time, rsp_if.mirroring);
          errors++;
        end else begin
          want = expected_views.pop_front();
          check_field("mirroring", 5'(want.mirroring), 5'(rsp_if.mirroring));
          check_field("prg_bank_first", 5'(want.prg_first), 5'(rsp_if.prg_bank_first));
          check_field("prg_bank_second", 5'(want.prg_second), 5'(rsp_if.prg_bank_second));
          check_field("chr_bank_first", want.chr_first, rsp_if.chr_bank_first);
          check_field("chr_bank_second", want.chr_second, rsp_if.chr_bank_second);
          check_field("prg_ram_writable", 5'(want.ram_writable), 5'(rsp_if.prg_ram_writable));
          check_field("register_loaded", 5'(want.loaded), 5'(rsp_if.register_loaded));
          views_checked++;
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_config(cfg_index_t'(cfg_if.index), cfg_if.data);
      end
      if (req_if.valid && req_if.ready) begin
        want = apply_write(req_if.write_address, req_if.write_data);
        expected_views.push_back(want);
        if (want.loaded) loads_seen++;
      end
    end
  end

  always @(negedge clk) begin
    rsp_if.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [AddrW-1:0] pick_address(target_t tgt);
    logic [AddrW-1:0] a;
    a = AddrW'($urandom_range(0, 65535));
    a[15] = ($urandom_range(7) != 0);
    a[14:13] = tgt;
    return a;
  endfunction

  task automatic send_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    int gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid         = 1'b1;
    req_if.write_address = addr;
    req_if.write_data    = data;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    writes_sent++;
  endtask

  // five serial writes; only the last address picks the target
  task automatic load_register(logic [AddrW-1:0] last_addr, logic [ShiftW-1:0] value);
    logic [AddrW-1:0] a;
    for (int i = 0; i < ShiftW; i++) begin
      a = (i == ShiftW - 1) ? last_addr : pick_address(target_t'($urandom_range(3)));
      send_write(a, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [CfgDataW-1:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic set_geometry(logic [2:0] pbits, logic [2:0] cbits, logic ram, logic [1:0] mir);
    wait_drained();
    cfg_write(CFG_PRG_BANK_BITS, pbits);
    cfg_write(CFG_CHR_BANK_BITS, cbits);
    cfg_write(CFG_CHR_IS_RAM, {2'($urandom), ram});
    cfg_write(CFG_POWER_ON_MIRROR, {1'($urandom), mir});
  endtask

  // mostly full loads with random content, the rest broken loads and stray writes
  task automatic run_traffic(int count);
    int stop_at;
    int kind;
    int partial;
    stop_at = writes_sent + count;
    while (writes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        load_register(pick_address(target_t'($urandom_range(3))), ShiftW'($urandom));
      end else if (kind < 85) begin
        partial = $urandom_range(1, ShiftW - 1);
        repeat (partial) send_write(pick_address(target_t'($urandom_range(3))),
                                    {1'b0, 7'($urandom)});
        send_write(pick_address(target_t'($urandom_range(3))), {1'b1, 7'($urandom)});
      end else begin
        send_write(pick_address(target_t'($urandom_range(3))), DataW'($urandom));
      end
    end
  endtask

  task automatic test_directed_loads();
    send_write(16'h8000, 8'h80);
    load_register(16'h1FFF, 5'b10011);
    load_register(16'hBFFF, 5'b11111);
    load_register(16'hC000, 5'b10101);
    load_register(16'hFFFF, 5'b11111);
    send_write(16'hFFFF, 8'h7F);
    send_write(16'h0000, 8'h00);
    send_write(16'hE000, 8'hFF);
  endtask

  task automatic test_power_on_mirroring();
    for (int m = 0; m < 4; m++) begin
      wait_drained();
      cfg_write(CFG_POWER_ON_MIRROR, {1'($urandom), 2'(m)});
      send_write(pick_address(TGT_CONTROL), 8'h80);
    end
  endtask

  task automatic test_bank_geometry();
    set_geometry(3'd0, 3'd0, 1'b0, 2'd0);
    run_traffic(100);
    set_geometry(3'd4, 3'd5, 1'b0, 2'd1);
    run_traffic(100);
    set_geometry(3'd7, 3'd7, 1'b0, 2'd3);
    run_traffic(100);
    set_geometry(3'd2, 3'd3, 1'b1, 2'd2);
    run_traffic(100);
    set_geometry(3'd1, 3'd4, 1'b0, 2'd1);
    run_traffic(100);
    set_geometry(3'd3, 3'd5, 1'b0, 2'd2);
    run_traffic(100);
  endtask

  task automatic test_flow_control();
    int send_pct[4] = '{0, 45, 0, 15};
    int recv_pct[4] = '{0, 0, 45, 15};
    for (int p = 0; p < 4; p++) begin
      set_geometry(3'($urandom), 3'($urandom), ($urandom_range(3) == 0), 2'($urandom));
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      run_traffic(225);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    req_if.valid         = 1'b0;
    req_if.write_address = '0;
    req_if.write_data    = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_PRG_BANK_BITS;
    cfg_if.data          = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed_loads();
    test_power_on_mirroring();
    test_bank_geometry();
    test_flow_control();

    wait_drained();
    repeat (5) @(negedge clk);
    $display("Covered %0d writes, %0d results checked, %0d register loads, %0d config writes",
             writes_sent, views_checked, loads_seen, cfg_writes);
    $display("Bank geometries from empty to oversized, pattern RAM, and four idle/stall mixes");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
